### rtl/drm_pkg.sv
// shared types and constants for the decimal register machine
package drm_pkg;

	// fixed field widths
	localparam int WORD_W = 10;
	localparam int CNT_W  = 32;
	localparam int REGS   = 10;
	localparam int RIDX_W = $clog2(REGS);
	localparam int KIND_W = 4;
	localparam int OP_W   = 2;

	// decimal constants
	localparam logic [WORD_W-1:0] WORD_MOD = 10'd1000;

	// item opcodes
	localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
	localparam logic [OP_W-1:0] OP_START = 2'd1;
	localparam logic [OP_W-1:0] OP_EXEC  = 2'd2;

	// instruction types (hundreds digit)
	localparam logic [KIND_W-1:0] K_GOTO  = 4'd0;
	localparam logic [KIND_W-1:0] K_HALT  = 4'd1;
	localparam logic [KIND_W-1:0] K_SET_I = 4'd2;
	localparam logic [KIND_W-1:0] K_ADD_I = 4'd3;
	localparam logic [KIND_W-1:0] K_MUL_I = 4'd4;
	localparam logic [KIND_W-1:0] K_SET_R = 4'd5;
	localparam logic [KIND_W-1:0] K_ADD_R = 4'd6;
	localparam logic [KIND_W-1:0] K_MUL_R = 4'd7;
	localparam logic [KIND_W-1:0] K_LOAD  = 4'd8;
	localparam logic [KIND_W-1:0] K_STORE = 4'd9;

	// controller to datapath commands
	typedef struct packed {
		logic latch_in;
		logic clear_step;
		logic load_write;
		logic start;
		logic fetch;
		logic dec1;
		logic dec2;
		logic dec3;
		logic rf_read;
		logic jump;
		logic halt;
		logic store;
		logic mem_read_op;
		logic arith;
		logic mul;
		logic mem_take;
		logic mul1;
		logic mul2;
		logic wb;
		logic out_load;
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic              clear_last;
		logic              running;
		logic [OP_W-1:0]   op;
		logic [KIND_W-1:0] kind;
	} sts_t;

endpackage

### rtl/drm_ctrl.sv
// controller state machine for the decimal register machine
module drm_ctrl import drm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic item_valid,
	output logic item_ready,
	output logic result_valid,
	input  logic result_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_DISPATCH, S_LOADW, S_START, S_FETCH, S_DEC1, S_DEC2,
		S_DEC3, S_RDREG, S_EXEC, S_MEMRD, S_MUL1, S_MUL2, S_WB, S_RESP
	} state_t;

	state_t state_q;
	logic   result_valid_q;

	assign item_ready   = (state_q == S_IDLE);
	assign result_valid = result_valid_q;

	// command decode
	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_CLEAR:    cmd.clear_step = 1'b1;
			S_IDLE:     cmd.latch_in   = item_valid;
			S_DISPATCH: ;
			S_LOADW:    cmd.load_write = 1'b1;
			S_START:    cmd.start      = 1'b1;
			S_FETCH:    cmd.fetch      = 1'b1;
			S_DEC1:     cmd.dec1       = 1'b1;
			S_DEC2:     cmd.dec2       = 1'b1;
			S_DEC3:     cmd.dec3       = 1'b1;
			S_RDREG:    cmd.rf_read    = 1'b1;
			S_EXEC: begin
				unique case (sts.kind)
					K_GOTO:                            cmd.jump        = 1'b1;
					K_HALT:                            cmd.halt        = 1'b1;
					K_SET_I, K_ADD_I, K_SET_R, K_ADD_R: cmd.arith       = 1'b1;
					K_MUL_I, K_MUL_R:                  cmd.mul         = 1'b1;
					K_LOAD:                            cmd.mem_read_op = 1'b1;
					K_STORE:                           cmd.store       = 1'b1;
					default: ;
				endcase
			end
			S_MEMRD:    cmd.mem_take   = 1'b1;
			S_MUL1:     cmd.mul1       = 1'b1;
			S_MUL2:     cmd.mul2       = 1'b1;
			S_WB:       cmd.wb         = 1'b1;
			S_RESP:     cmd.out_load   = !result_valid_q || result_ready;
			default: ;
		endcase
	end

	// state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_CLEAR;
			result_valid_q <= 1'b0;
		end else begin
			if (result_ready && !cmd.out_load) result_valid_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: if (sts.clear_last) state_q <= S_IDLE;
				S_IDLE:  if (item_valid) state_q <= S_DISPATCH;
				S_DISPATCH: begin
					unique case (sts.op)
						OP_LOAD:  state_q <= S_LOADW;
						OP_START: state_q <= S_START;
						OP_EXEC:  state_q <= sts.running ? S_FETCH : S_RESP;
						default:  state_q <= S_RESP;
					endcase
				end
				S_LOADW: state_q <= S_RESP;
				S_START: state_q <= S_RESP;
				S_FETCH: state_q <= S_DEC1;
				S_DEC1:  state_q <= S_DEC2;
				S_DEC2:  state_q <= S_DEC3;
				S_DEC3:  state_q <= S_RDREG;
				S_RDREG: state_q <= S_EXEC;
				S_EXEC: begin
					unique case (sts.kind)
						K_SET_I, K_ADD_I, K_SET_R, K_ADD_R: state_q <= S_WB;
						K_MUL_I, K_MUL_R:                  state_q <= S_MUL1;
						K_LOAD:                            state_q <= S_MEMRD;
						default:                           state_q <= S_RESP;
					endcase
				end
				S_MEMRD: state_q <= S_WB;
				S_MUL1:  state_q <= S_MUL2;
				S_MUL2:  state_q <= S_WB;
				S_WB:    state_q <= S_RESP;
				S_RESP: begin
					if (cmd.out_load) begin
						result_valid_q <= 1'b1;
						state_q        <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// an accepted beat always goes to dispatch
	a_accept_dispatch: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && item_ready) |=> (state_q == S_DISPATCH))
		else $error("accepted beat did not reach dispatch");

	// loading the result register raises result valid
	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> result_valid_q)
		else $error("result loaded without valid");

endmodule

### rtl/drm_dpath.sv
// datapath: word memory, register file, decoder, arithmetic and result register
module drm_dpath import drm_pkg::*; #(
	parameter int MEM_DEPTH = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	output sts_t              sts,
	input  logic [OP_W-1:0]   opcode,
	input  logic [WORD_W-1:0] load_address,
	input  logic [WORD_W-1:0] load_value,
	output logic              is_running,
	output logic [WORD_W-1:0] program_counter,
	output logic [CNT_W-1:0]  executed_count
);

	localparam int AW = $clog2(MEM_DEPTH);

	// architectural state
	logic [WORD_W-1:0] pc_q;
	logic              run_q;
	logic [CNT_W-1:0]  tally_q;
	logic [REGS-1:0]   rf_vld_q;
	logic [AW-1:0]     clr_q;

	// latched beat
	logic [OP_W-1:0]   op_q;
	logic [WORD_W-1:0] addr_q;
	logic [WORD_W-1:0] val_q;

	// decode and operand registers
	logic [WORD_W-1:0] word_q;
	logic [KIND_W-1:0] kind_q;
	logic [6:0]        rem_q;
	logic [RIDX_W-1:0] d_q;
	logic [RIDX_W-1:0] n_q;
	logic [WORD_W-1:0] rd_raw_q;
	logic [WORD_W-1:0] rn_raw_q;
	logic              rd_v_q;
	logic              rn_v_q;
	logic [19:0]       acc_q;
	logic [WORD_W-1:0] qest_q;

	// memories
	logic [WORD_W-1:0] wmem [MEM_DEPTH];
	logic [WORD_W-1:0] rf_mem [REGS];
	logic [WORD_W-1:0] mem_q;
	logic              mem_ok_q;

	// result register
	logic              run_out_q;
	logic [WORD_W-1:0] pc_out_q;
	logic [CNT_W-1:0]  tally_out_q;

	logic [WORD_W-1:0] rd;
	logic [WORD_W-1:0] rn;
	logic [WORD_W-1:0] val_mod;
	logic [WORD_W-1:0] word;
	logic [15:0]       kprod;
	logic [16:0]       dprod;
	logic [RIDX_W-1:0] d_dig;
	logic              imm;
	logic [WORD_W-1:0] opa;
	logic [WORD_W-1:0] opb;
	logic [30:0]       qprod;
	logic [WORD_W-1:0] wb_val;
	logic              mem_we;
	logic [WORD_W-1:0] mem_wa;
	logic [WORD_W-1:0] mem_wd;
	logic              mem_re;
	logic [WORD_W-1:0] mem_ra;

	assign rd      = rd_v_q ? rd_raw_q : '0;
	assign rn      = rn_v_q ? rn_raw_q : '0;
	assign val_mod = (val_q >= WORD_MOD) ? (val_q - WORD_MOD) : val_q;

	// digit split by reciprocal multiplies
	assign word  = mem_ok_q ? mem_q : '0;
	assign kprod = 16'(word) * 16'd41;
	assign dprod = 17'(rem_q) * 17'd103;
	assign d_dig = dprod[13:10];

	// operand select
	assign imm = (kind_q == K_SET_I) || (kind_q == K_ADD_I) || (kind_q == K_MUL_I);
	assign opb = imm ? WORD_W'(n_q) : rn;
	assign opa = ((kind_q == K_ADD_I) || (kind_q == K_ADD_R)) ? rd : '0;
	assign qprod = 31'(acc_q) * 31'd1048;
	assign wb_val = (acc_q >= 20'(WORD_MOD)) ? 10'(acc_q - 20'(WORD_MOD)) : acc_q[9:0];

	// word memory port control
	always_comb begin
		mem_we = cmd.clear_step
			|| (cmd.load_write && (32'(addr_q) < MEM_DEPTH))
			|| (cmd.store && (32'(rn) < MEM_DEPTH));
		if (cmd.clear_step) begin
			mem_wa = WORD_W'(clr_q);
			mem_wd = '0;
		end else if (cmd.load_write) begin
			mem_wa = addr_q;
			mem_wd = val_mod;
		end else begin
			mem_wa = rn;
			mem_wd = rd;
		end
		mem_re = cmd.fetch || cmd.mem_read_op;
		mem_ra = cmd.fetch ? pc_q : rn;
	end

	// word memory
	always_ff @(posedge clk) begin
		if (mem_we) wmem[mem_wa[AW-1:0]] <= mem_wd;
		if (mem_re) begin
			mem_q    <= wmem[mem_ra[AW-1:0]];
			mem_ok_q <= (32'(mem_ra) < MEM_DEPTH);
		end
	end

	// register file
	always_ff @(posedge clk) begin
		if (cmd.wb) rf_mem[d_q] <= wb_val;
		if (cmd.rf_read) begin
			rd_raw_q <= rf_mem[d_q];
			rn_raw_q <= rf_mem[n_q];
			rd_v_q   <= rf_vld_q[d_q];
			rn_v_q   <= rf_vld_q[n_q];
		end
	end

	// control state: pc, run flag, tally, valid bits, clear counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q     <= '0;
			run_q    <= 1'b0;
			tally_q  <= '0;
			rf_vld_q <= '0;
			clr_q    <= '0;
		end else begin
			if (cmd.clear_step) clr_q <= clr_q + 1'b1;
			if (cmd.start) begin
				pc_q     <= '0;
				run_q    <= 1'b1;
				tally_q  <= '0;
				rf_vld_q <= '0;
			end
			if (cmd.fetch) begin
				pc_q <= pc_q + 1'b1;
				if (tally_q != '1) tally_q <= tally_q + 1'b1;
			end
			if (cmd.jump && (rn != '0)) pc_q <= rd;
			if (cmd.halt) run_q <= 1'b0;
			if (cmd.wb) rf_vld_q[d_q] <= 1'b1;
		end
	end

	// beat latch, decode and arithmetic
	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			op_q   <= opcode;
			addr_q <= load_address;
			val_q  <= load_value;
		end
		if (cmd.dec1) begin
			word_q <= word;
			kind_q <= kprod[15:12];
		end
		if (cmd.dec2) rem_q <= 7'(word_q - 10'(kind_q) * 10'd100);
		if (cmd.dec3) begin
			d_q <= d_dig;
			n_q <= RIDX_W'(rem_q - 7'(d_dig) * 7'd10);
		end
		if (cmd.arith)    acc_q <= 20'(opa) + 20'(opb);
		if (cmd.mul)      acc_q <= 20'(rd) * 20'(opb);
		if (cmd.mem_take) acc_q <= mem_ok_q ? 20'(mem_q) : '0;
		if (cmd.mul1)     qest_q <= qprod[29:20];
		if (cmd.mul2)     acc_q <= acc_q - 20'(qest_q) * 20'd1000;
		if (cmd.out_load) begin
			run_out_q   <= run_q;
			pc_out_q    <= pc_q;
			tally_out_q <= tally_q;
		end
	end

	assign is_running      = run_out_q;
	assign program_counter = pc_out_q;
	assign executed_count  = tally_out_q;

	assign sts.clear_last = (clr_q == AW'(MEM_DEPTH - 1));
	assign sts.running    = run_q;
	assign sts.op         = op_q;
	assign sts.kind       = kind_q;

	// the word memory serves one access per cycle
	a_mem_port: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.clear_step, cmd.load_write, cmd.store, cmd.fetch, cmd.mem_read_op}))
		else $error("word memory accessed twice in one cycle");

	// register write back stays a three digit value
	a_wb_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wb |-> (wb_val < WORD_MOD))
		else $error("write back value out of decimal range");

	// decoded digits are decimal
	a_digits: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.dec3 |=> ((d_q < 4'd10) && (n_q < 4'd10)))
		else $error("decoded digit out of range");

endmodule

### rtl/decimal_register_machine_step.sv
// top level of the decimal register machine
// Each beat on the item channel loads a memory word, starts a run, or executes one
// instruction while running (an execute while halted or an unused opcode changes
// nothing); exactly one result beat follows, giving the run flag, program counter
// and saturating executed count after the item. Items are handled one at a time by a
// state machine stepping a datapath whose word memory and register file are single
// synchronous memories: fetch, decode, operand read and write back are separate
// controller states, a memory load adds a memory read state, and a multiply adds
// the MUL1 and MUL2 states for the modulo-1000 reduction by reciprocal multiply. The
// next item can be accepted while a result waits on the output register. After reset
// the word memory is cleared one word per cycle, and no item is accepted until the
// last word is cleared.
module decimal_register_machine_step import drm_pkg::*; #(
	parameter int MEM_DEPTH = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  logic [OP_W-1:0]   opcode,
	input  logic [WORD_W-1:0] load_address,
	input  logic [WORD_W-1:0] load_value,
	output logic              result_valid,
	input  logic              result_ready,
	output logic              is_running,
	output logic [WORD_W-1:0] program_counter,
	output logic [CNT_W-1:0]  executed_count
);

	cmd_t cmd;
	sts_t sts;

	// sequencer
	drm_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.sts          (sts),
		.cmd          (cmd)
	);

	// storage and arithmetic
	drm_dpath #(
		.MEM_DEPTH (MEM_DEPTH)
	) u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.opcode          (opcode),
		.load_address    (load_address),
		.load_value      (load_value),
		.is_running      (is_running),
		.program_counter (program_counter),
		.executed_count  (executed_count)
	);

endmodule

### tb/decimal_register_machine_step_test.sv
// self-checking testbench for the decimal register machine step block
module decimal_register_machine_step_test import drm_pkg::*; ;

	timeunit 1ns;
	timeprecision 1ps;

	// opcode value the block has no use for
	localparam logic [OP_W-1:0] OP_NONE = 2'd3;
	localparam int unsigned KIND_DIV = 100;
	localparam int unsigned DIGIT_DIV = 10;
	localparam int TOTAL_WORK_ITEMS = 850;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int SETTLE_CYCLES = 30;

	typedef struct packed {
		logic              running;
		logic [WORD_W-1:0] pc;
		logic [CNT_W-1:0]  count;
	} machine_status_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              item_valid = 1'b0;
	logic              item_ready;
	logic [OP_W-1:0]   opcode = OP_LOAD;
	logic [WORD_W-1:0] load_address = '0;
	logic [WORD_W-1:0] load_value = '0;
	logic              result_valid;
	logic              result_ready = 1'b0;
	logic              is_running;
	logic [WORD_W-1:0] program_counter;
	logic [CNT_W-1:0]  executed_count;

	// machine state as the testbench expects it
	logic [WORD_W-1:0] mem_words [0:1023];
	logic [WORD_W-1:0] reg_values [0:REGS-1];
	logic [WORD_W-1:0] fetch_pc = '0;
	logic              run_flag = 1'b0;
	logic [CNT_W-1:0]  step_count = '0;

	machine_status_t expected_status [$];
	machine_status_t head_status;
	int mismatch_count = 0;
	int work_items = 0;
	int quiet_cycles = 0;
	bit sender_gaps_on = 1'b1;
	bit receiver_stalls_on = 1'b1;

	decimal_register_machine_step dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.opcode(opcode),
		.load_address(load_address),
		.load_value(load_value),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.is_running(is_running),
		.program_counter(program_counter),
		.executed_count(executed_count)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		foreach (mem_words[i]) mem_words[i] = '0;
		foreach (reg_values[i]) reg_values[i] = '0;
	end

	// idle stretch: mostly short, now and then long
	function automatic int idle_length();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(8, 40);
		return $urandom_range(1, 3);
	endfunction

	function automatic logic [WORD_W-1:0] encode(input logic [KIND_W-1:0] kind,
			input int unsigned d, input int unsigned n);
		return WORD_W'(kind * KIND_DIV + d * DIGIT_DIV + n);
	endfunction

	// random instruction word, halts kept rare so programs run a while
	function automatic logic [WORD_W-1:0] random_word();
		logic [KIND_W-1:0] kind;
		if ($urandom_range(0, 19) == 0)
			return WORD_W'($urandom_range(0, 1023));
		kind = KIND_W'($urandom_range(K_GOTO, K_STORE));
		if (kind == K_HALT && $urandom_range(0, 3) != 0)
			kind = K_ADD_I;
		return encode(kind, $urandom_range(0, 9), $urandom_range(0, 9));
	endfunction

	// advance the expected machine by one accepted item and queue its status
	task automatic predict_item(input logic [OP_W-1:0] op, input logic [WORD_W-1:0] addr,
			input logic [WORD_W-1:0] value);
		int unsigned word, dsel, nsel, rd, rn, res;
		logic [KIND_W-1:0] kind;
		bit writes_reg;
		machine_status_t st;
		work_items++;
		if (op == OP_LOAD) begin
			mem_words[addr] = value % WORD_MOD;
		end else if (op == OP_START) begin
			foreach (reg_values[i]) reg_values[i] = '0;
			fetch_pc = '0;
			step_count = '0;
			run_flag = 1'b1;
		end else if (op == OP_EXEC && run_flag) begin
			word = mem_words[fetch_pc];
			kind = KIND_W'(word / KIND_DIV);
			dsel = (word % KIND_DIV) / DIGIT_DIV;
			nsel = word % DIGIT_DIV;
			rd = reg_values[dsel];
			rn = reg_values[nsel];
			res = rd;
			writes_reg = 1'b1;
			if (step_count != '1)
				step_count++;
			fetch_pc++;
			case (kind)
				K_GOTO: begin
					writes_reg = 1'b0;
					if (rn != 0)
						fetch_pc = WORD_W'(rd);
				end
				K_HALT: begin
					writes_reg = 1'b0;
					run_flag = 1'b0;
				end
				K_SET_I: res = nsel;
				K_ADD_I: res = rd + nsel;
				K_MUL_I: res = rd * nsel;
				K_SET_R: res = rn;
				K_ADD_R: res = rd + rn;
				K_MUL_R: res = rd * rn;
				K_LOAD:  res = mem_words[rn];
				default: begin
					writes_reg = 1'b0;
					mem_words[rn] = WORD_W'(rd);
				end
			endcase
			if (writes_reg)
				reg_values[dsel] = WORD_W'(res % WORD_MOD);
		end
		st.running = run_flag;
		st.pc = fetch_pc;
		st.count = step_count;
		expected_status.push_back(st);
	endtask

	// drive one item beat, wait for it to be taken, then maybe idle
	task automatic send_item(input logic [OP_W-1:0] op, input logic [WORD_W-1:0] addr,
			input logic [WORD_W-1:0] value);
		int gap;
		@(negedge clk);
		item_valid <= 1'b1;
		opcode <= op;
		load_address <= addr;
		load_value <= value;
		@(posedge clk);
		while (!item_ready)
			@(posedge clk);
		predict_item(op, addr, value);
		gap = (!sender_gaps_on || $urandom_range(0, 99) < 55) ? 0 : idle_length();
		if (gap > 0) begin
			@(negedge clk);
			item_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic send_random_item();
		send_item(OP_W'($urandom_range(OP_LOAD, OP_NONE)), WORD_W'($urandom_range(0, 1023)),
			WORD_W'($urandom_range(0, 1023)));
	endtask

	// hold the item side until every queued status has come back
	task automatic wait_drained();
		@(negedge clk);
		item_valid <= 1'b0;
		while (expected_status.size() != 0)
			@(posedge clk);
	endtask

	// extremes of the item fields, unused opcode, execute before any start
	task automatic test_field_edges();
		send_item(OP_EXEC, '0, '0);
		send_item(OP_NONE, '1, '1);
		send_item(OP_LOAD, '1, '1);
		send_item(OP_LOAD, 10'd512, 10'd1000);
		send_item(OP_LOAD, '0, 10'd999);
		send_item(OP_EXEC, '1, '1);
	endtask

	// short program touching every instruction type, ending in a halt
	task automatic test_instruction_set();
		send_item(OP_LOAD, 10'd0, encode(K_SET_I, 5, 9));
		send_item(OP_LOAD, 10'd1, encode(K_ADD_I, 5, 5));
		send_item(OP_LOAD, 10'd2, encode(K_MUL_I, 5, 5));
		send_item(OP_LOAD, 10'd3, encode(K_SET_R, 4, 5));
		send_item(OP_LOAD, 10'd4, encode(K_ADD_R, 4, 5));
		send_item(OP_LOAD, 10'd5, encode(K_MUL_R, 4, 4));
		send_item(OP_LOAD, 10'd6, encode(K_STORE, 5, 4));
		send_item(OP_LOAD, 10'd7, encode(K_LOAD, 3, 4));
		send_item(OP_LOAD, 10'd8, encode(K_GOTO, 5, 3));
		send_item(OP_LOAD, 10'd70, encode(K_HALT, 0, 0));
		send_item(OP_START, '1, '1);
		repeat (10) send_item(OP_EXEC, WORD_W'($urandom_range(0, 1023)), '0);
		send_item(OP_EXEC, '0, '1);
		send_item(OP_NONE, '0, '0);
	endtask

	// jump to 999 and step off the top of the address space back to zero
	task automatic test_fetch_wrap();
		send_item(OP_LOAD, 10'd0, encode(K_SET_I, 2, 5));
		send_item(OP_LOAD, 10'd1, encode(K_LOAD, 1, 2));
		send_item(OP_LOAD, 10'd2, encode(K_GOTO, 1, 2));
		send_item(OP_LOAD, 10'd5, 10'd999);
		for (int a = 999; a <= 1023; a++)
			send_item(OP_LOAD, WORD_W'(a), encode(KIND_W'($urandom_range(K_SET_I, K_LOAD)),
				$urandom_range(0, 9), $urandom_range(0, 9)));
		wait_drained();
		send_item(OP_START, '0, '0);
		repeat (32) send_item(OP_EXEC, WORD_W'($urandom_range(0, 1023)),
			WORD_W'($urandom_range(0, 1023)));
	endtask

	// load a random program at zero, start it and step it with some noise mixed in
	task automatic run_program_round();
		int unsigned len;
		int unsigned steps;
		len = $urandom_range(3, 20);
		for (int i = 0; i < len; i++)
			send_item(OP_LOAD, WORD_W'(i), random_word());
		repeat ($urandom_range(0, 3))
			send_item(OP_LOAD, WORD_W'($urandom_range(0, 1023)), WORD_W'($urandom_range(0, 1023)));
		send_item(OP_START, WORD_W'($urandom_range(0, 1023)), WORD_W'($urandom_range(0, 1023)));
		steps = $urandom_range(len, 3 * len);
		repeat (steps) begin
			if ($urandom_range(0, 19) == 0)
				send_random_item();
			else
				send_item(OP_EXEC, WORD_W'($urandom_range(0, 1023)), WORD_W'($urandom_range(0, 1023)));
		end
	endtask

	task automatic test_random_programs();
		int round_no;
		round_no = 0;
		while (work_items < TOTAL_WORK_ITEMS) begin
			sender_gaps_on = ($urandom_range(0, 9) < 7);
			receiver_stalls_on = ($urandom_range(0, 9) < 7);
			if (round_no % 8 == 3)
				wait_drained();
			run_program_round();
			round_no++;
		end
	endtask

	// result side: ready with random stalls
	initial begin
		int stall_left;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				result_ready <= 1'b0;
				stall_left--;
			end else if (receiver_stalls_on && $urandom_range(0, 99) < 25) begin
				stall_left = idle_length() - 1;
				result_ready <= 1'b0;
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	function automatic void compare_field(input string label, input logic [CNT_W-1:0] want,
			input logic [CNT_W-1:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0d actual %0d", $time, label, want, got);
			mismatch_count++;
		end
	endfunction

	// compare each result beat with the oldest expected status
	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready) begin
			if (expected_status.size() == 0) begin
				$display("%0t: result beat with no status expected", $time);
				mismatch_count++;
			end else begin
				head_status = expected_status.pop_front();
				compare_field("is_running", CNT_W'(head_status.running), CNT_W'(is_running));
				compare_field("program_counter", CNT_W'(head_status.pc), CNT_W'(program_counter));
				compare_field("executed_count", head_status.count, executed_count);
			end
		end
	end

	// stop a hung run: no beat on either side for too long
	always @(posedge clk) begin
		if ((item_valid && item_ready) || (result_valid && result_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("%0t: no beat accepted for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_field_edges();
		test_instruction_set();
		test_fetch_wrap();
		test_random_programs();
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
